// File: design/b64e_pkg.sv
// Shared types, character codes and the base64 symbol lookup.
package b64e_pkg;

   localparam int MAX_RESULTS = 7;
   localparam int COUNT_W = 3;

   localparam logic [7:0] CHAR_PAD = 8'h3D;
   localparam logic [7:0] CHAR_NEWLINE = 8'h0A;

   localparam logic [1:0] CSR_URL_SAFE = 2'd0;
   localparam logic [1:0] CSR_PAD_ENABLE = 2'd1;
   localparam logic [1:0] CSR_WRAP_WIDTH = 2'd2;

   localparam logic [1:0] PHASE_FIRST = 2'd0;
   localparam logic [1:0] PHASE_SECOND = 2'd1;
   localparam logic [1:0] PHASE_THIRD = 2'd2;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       final_byte;
   } request_type;

   typedef struct packed {
      logic        url_safe;
      logic        pad_enable;
      logic [15:0] wrap_width;
   } csr_type;

   typedef struct packed {
      logic [7:0] out_char;
      logic       run_end;
      logic       message_end;
   } item_type;

   typedef struct packed {
      item_type [MAX_RESULTS-1:0] items;
      logic [COUNT_W-1:0]         count;
   } expansion_type;

   function automatic logic [7:0] b64_symbol(input logic [5:0] v, input logic url);
      logic [7:0] v8;
      v8 = {2'b00, v};
      if (v < 6'd26) begin
         return 8'h41 + v8;
      end else if (v < 6'd52) begin
         return 8'h61 + v8 - 8'd26;
      end else if (v < 6'd62) begin
         return 8'h30 + v8 - 8'd52;
      end else if (v == 6'd62) begin
         return url ? 8'h2D : 8'h2B;
      end else begin
         return url ? 8'h5F : 8'h2F;
      end
   endfunction

endpackage

// File: design/b64e_input_stage.sv
// Input register that holds one request until the encoder takes it.
module b64e_input_stage
   import b64e_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  request_type req_in,
   output logic        hold_valid,
   output request_type hold_request,
   input  logic        take
);

   logic        valid_ff;
   logic        valid_in;
   request_type request_ff;

   assign req_stall = valid_ff && !take;
   assign valid_in = req_stall ? valid_ff : req_valid;
   assign hold_valid = valid_ff;
   assign hold_request = request_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall && req_valid) begin
         request_ff <= req_in;
      end
   end

endmodule

// File: design/b64e_encoder.sv
// Group and line state plus the expansion of one byte into its characters.
module b64e_encoder
   import b64e_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  csr_type       csr,
   input  request_type   request,
   input  logic          take,
   output expansion_type expansion
);

   logic [1:0]  phase_ff, phase_in;
   logic [3:0]  carry_ff, carry_in;
   logic [15:0] column_ff, column_in;

   logic [7:0]         chars [4];
   logic [2:0]         n_chars;
   logic [15:0]        col;
   logic               last_char;
   logic               newline;
   logic [COUNT_W-1:0] pos;
   logic [7:0]         b;
   logic               fin;
   logic               url;
   logic               pad;

   assign b = request.data_byte;
   assign fin = request.final_byte;
   assign url = csr.url_safe;
   assign pad = csr.pad_enable;

   always_comb begin
      chars[0] = b64_symbol(b[7:2], url);
      chars[1] = '0;
      chars[2] = CHAR_PAD;
      chars[3] = CHAR_PAD;
      n_chars = 3'd1;
      phase_in = PHASE_SECOND;
      carry_in = {2'b00, b[1:0]};
      unique case (phase_ff)
         PHASE_SECOND: begin
            chars[0] = b64_symbol({carry_ff[1:0], b[7:4]}, url);
            chars[1] = b64_symbol({b[3:0], 2'b00}, url);
            n_chars = fin ? (pad ? 3'd3 : 3'd2) : 3'd1;
            phase_in = PHASE_THIRD;
            carry_in = b[3:0];
         end
         PHASE_THIRD: begin
            chars[0] = b64_symbol({carry_ff, b[7:6]}, url);
            chars[1] = b64_symbol(b[5:0], url);
            n_chars = 3'd2;
            phase_in = PHASE_FIRST;
            carry_in = '0;
         end
         default: begin
            chars[1] = b64_symbol({b[1:0], 4'b0000}, url);
            n_chars = fin ? (pad ? 3'd4 : 3'd2) : 3'd1;
         end
      endcase
      if (fin) begin
         phase_in = PHASE_FIRST;
         carry_in = '0;
      end
   end

   always_comb begin
      expansion.items = '0;
      col = column_ff;
      pos = '0;
      last_char = 1'b0;
      newline = 1'b0;
      for (int i = 0; i < 4; i++) begin
         if (3'(i) < n_chars) begin
            last_char = fin && (3'(i) == n_chars - 3'd1);
            expansion.items[pos].out_char = chars[i];
            pos = pos + 3'd1;
            newline = 1'b0;
            if (csr.wrap_width != 16'd0) begin
               col = col + 16'd1;
               newline = !last_char && (col >= csr.wrap_width);
            end else begin
               col = '0;
            end
            if (newline) begin
               expansion.items[pos].out_char = CHAR_NEWLINE;
               pos = pos + 3'd1;
               col = '0;
            end
         end
      end
      expansion.items[pos - 3'd1].run_end = 1'b1;
      expansion.items[pos - 3'd1].message_end = fin;
      expansion.count = pos;
      column_in = fin ? 16'd0 : col;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PHASE_FIRST;
         carry_ff <= '0;
         column_ff <= '0;
      end else if (take) begin
         phase_ff <= phase_in;
         carry_ff <= carry_in;
         column_ff <= column_in;
      end
   end

endmodule

// File: design/b64e_output_queue.sv
// Result register queue that presents the characters of one request in order.
module b64e_output_queue
   import b64e_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          load_valid,
   input  expansion_type expansion,
   output logic          take,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output item_type      rsp_item
);

   logic [COUNT_W-1:0] count_ff, count_in;
   item_type           items_ff [MAX_RESULTS];
   item_type           items_in [MAX_RESULTS];
   logic               pop;
   logic               room;

   assign rsp_valid = count_ff != '0;
   assign rsp_item = items_ff[0];
   assign pop = rsp_valid && !rsp_stall;
   assign room = (count_ff == '0) || ((count_ff == COUNT_W'(1)) && pop);
   assign take = room && load_valid;

   always_comb begin
      count_in = count_ff;
      for (int i = 0; i < MAX_RESULTS; i++) begin
         items_in[i] = items_ff[i];
      end
      if (take) begin
         count_in = expansion.count;
         for (int i = 0; i < MAX_RESULTS; i++) begin
            items_in[i] = expansion.items[i];
         end
      end else if (pop) begin
         count_in = count_ff - COUNT_W'(1);
         for (int i = 0; i < MAX_RESULTS - 1; i++) begin
            items_in[i] = items_ff[i + 1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < MAX_RESULTS; i++) begin
         items_ff[i] <= items_in[i];
      end
   end

endmodule

// File: design/base64_stream_encoder.sv
// Streaming base64 encoder with optional padding and line wrapping.
// Path: a request is held in the input register, then expanded and loaded into the output queue.
// Flow: the output queue loads the next held request in the cycle the last character of
// the previous one leaves, so no bubble between.
// Reset: synchronous; clears group, carry and column state, empties both stages,
// and sets standard alphabet, padding on, wrapping off.
module base64_stream_encoder
   import b64e_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_final_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_char,
   output logic        rsp_run_end,
   output logic        rsp_message_end,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   csr_type       csr_ff;
   request_type   req_in;
   request_type   hold_request;
   logic          hold_valid;
   logic          take;
   expansion_type expansion;
   item_type      rsp_item;

   assign csr_ready = 1'b1;
   assign req_in.data_byte = req_data_byte;
   assign req_in.final_byte = req_final_byte;
   assign rsp_out_char = rsp_item.out_char;
   assign rsp_run_end = rsp_item.run_end;
   assign rsp_message_end = rsp_item.message_end;

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.url_safe <= 1'b0;
         csr_ff.pad_enable <= 1'b1;
         csr_ff.wrap_width <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_URL_SAFE:   csr_ff.url_safe <= csr_wdata[0];
            CSR_PAD_ENABLE: csr_ff.pad_enable <= csr_wdata[0];
            CSR_WRAP_WIDTH: csr_ff.wrap_width <= csr_wdata;
            default: ;
         endcase
      end
   end

   b64e_input_stage u_input_stage (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_in       (req_in),
      .hold_valid   (hold_valid),
      .hold_request (hold_request),
      .take         (take)
   );

   b64e_encoder u_encoder (
      .clock     (clock),
      .reset     (reset),
      .csr       (csr_ff),
      .request   (hold_request),
      .take      (take),
      .expansion (expansion)
   );

   b64e_output_queue u_output_queue (
      .clock      (clock),
      .reset      (reset),
      .load_valid (hold_valid),
      .expansion  (expansion),
      .take       (take),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_item   (rsp_item)
   );

endmodule
